FILE: rtl/oidd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the object identifier content decoder
// no dependencies

package oidd_pkg;

    // first octet splits into two arcs around this divisor
    localparam int unsigned FIRST_DIVISOR = 40;
    // continuation flag position in a content octet
    localparam int unsigned CONT_BIT = 7;
    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // what a queued entry expands into on the output side
    typedef enum logic {
        ENTRY_PAIR = 1'b0,   // first octet: two arcs
        ENTRY_ARC  = 1'b1    // one completed or truncated arc
    } oidd_kind_t;

    // control part of a queued entry
    typedef struct packed {
        oidd_kind_t kind;
        logic [1:0] first_arc;   // leading arc of a pair entry
        logic       last_arc;
        logic       truncated;
    } oidd_ctrl_t;

endpackage

FILE: rtl/oid_ber_content_decoder_unit.sv
`timescale 1ns / 1ps
// top level of the BER object identifier content decoder
// depends on oidd_pkg, oidd_front, oidd_queue, oidd_back

// Decodes the content octets of an ASN.1 BER object identifier, one octet per
// transfer with tlast on the final octet, into arc numbers on the result
// stream. The first octet of an identifier gives two arcs (min(octet/40, 2)
// and the remainder); later octets build base-128 arcs in an ARC_WIDTH-bit
// accumulator that wraps, output as its low 32 bits. If the content ends on a
// continuation octet the partial arc is sent with tuser set. An octet is taken
// every cycle while the four-entry queue between the octet front and the arc
// back has room; the output side sends one arc per cycle while m_tready is
// high, so a first octet yields two arcs in a burst that the queue absorbs.

module oid_ber_content_decoder_unit #(
    parameter int unsigned ARC_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] content_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] arc_value
    output logic        m_tlast,   // last_arc
    output logic        m_tuser    // [0] truncated
);

    import oidd_pkg::*;

    localparam int unsigned ENTRY_W = $bits(oidd_ctrl_t) + ARC_WIDTH;

    logic                 in_xfer;
    logic                 push;
    oidd_ctrl_t           push_ctrl;
    logic [ARC_WIDTH-1:0] push_value;
    logic                 pop;
    logic [ENTRY_W-1:0]   head_data;
    oidd_ctrl_t           head_ctrl;
    logic [ARC_WIDTH-1:0] head_value;
    logic                 not_empty;
    logic                 full;

    // input transfer while the queue has room
    assign s_tready = !full;
    assign in_xfer  = s_tvalid && s_tready;

    oidd_front #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_xfer      (in_xfer),
        .content_byte (s_tdata),
        .last_byte    (s_tlast),
        .push         (push),
        .push_ctrl    (push_ctrl),
        .push_value   (push_value)
    );

    oidd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctrl, push_value}),
        .pop       (pop),
        .head_data (head_data),
        .not_empty (not_empty),
        .full      (full)
    );

    assign head_ctrl  = head_data[ENTRY_W-1:ARC_WIDTH];
    assign head_value = head_data[ARC_WIDTH-1:0];

    oidd_back #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (not_empty),
        .head_ctrl  (head_ctrl),
        .head_value (head_value),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: rtl/oidd_queue.sv
`timescale 1ns / 1ps
// small register queue that decouples the byte front from the arc back
// no package dependencies

module oidd_queue #(
    parameter int unsigned WIDTH = 37,
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_data = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/oidd_front.sv
`timescale 1ns / 1ps
// front part: takes content octets, splits the first octet, accumulates arcs
// depends on oidd_pkg

module oidd_front #(
    parameter int unsigned ARC_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_xfer,
    input  logic [7:0]              content_byte,
    input  logic                    last_byte,
    output logic                    push,
    output oidd_pkg::oidd_ctrl_t    push_ctrl,
    output logic [ARC_WIDTH-1:0]    push_value
);

    import oidd_pkg::*;

    logic                 at_start_reg, at_start_next;
    logic [ARC_WIDTH-1:0] acc_reg, acc_next;
    logic [ARC_WIDTH-1:0] acc_shifted;
    logic [1:0]           first_arc;
    logic [7:0]           second_arc;
    logic [ARC_WIDTH+7:0] second_wide;
    logic                 cont;

    assign cont        = content_byte[CONT_BIT];
    assign acc_shifted = {acc_reg[ARC_WIDTH-8:0], content_byte[6:0]};

    // split of the first octet by compare against 40 and 80
    always_comb begin
        if (content_byte >= 8'(2 * FIRST_DIVISOR)) begin
            first_arc  = 2'd2;
            second_arc = content_byte - 8'(2 * FIRST_DIVISOR);
        end else if (content_byte >= 8'(FIRST_DIVISOR)) begin
            first_arc  = 2'd1;
            second_arc = content_byte - 8'(FIRST_DIVISOR);
        end else begin
            first_arc  = 2'd0;
            second_arc = content_byte;
        end
    end

    assign second_wide = {ARC_WIDTH'(0), second_arc};

    // classify the transfer and build the queue entry
    always_comb begin
        at_start_next       = at_start_reg;
        acc_next            = acc_reg;
        push                = 1'b0;
        push_ctrl.kind      = ENTRY_ARC;
        push_ctrl.first_arc = first_arc;
        push_ctrl.last_arc  = last_byte;
        push_ctrl.truncated = 1'b0;
        push_value          = acc_shifted;
        if (in_xfer) begin
            if (at_start_reg) begin
                push           = 1'b1;
                push_ctrl.kind = ENTRY_PAIR;
                push_value     = second_wide[ARC_WIDTH-1:0];
                acc_next       = '0;
                at_start_next  = last_byte;
            end else if (last_byte) begin
                push                = 1'b1;
                push_ctrl.truncated = cont;
                acc_next            = '0;
                at_start_next       = 1'b1;
            end else if (!cont) begin
                push     = 1'b1;
                acc_next = '0;
            end else begin
                acc_next = acc_shifted;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            acc_reg      <= '0;
        end else begin
            at_start_reg <= at_start_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

FILE: rtl/oidd_back.sv
`timescale 1ns / 1ps
// back part: expands queue entries into arc transfers through an output register
// depends on oidd_pkg

module oidd_back #(
    parameter int unsigned ARC_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  oidd_pkg::oidd_ctrl_t  head_ctrl,
    input  logic [ARC_WIDTH-1:0]  head_value,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    import oidd_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_arc_reg, out_arc_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_trunc_reg, out_trunc_next;
    logic                  half_reg, half_next;
    logic                  out_free;
    logic [ARC_WIDTH+31:0] value_wide;

    assign out_free   = !out_valid_reg || m_tready;
    assign value_wide = {32'd0, head_value};

    // load the output register from the queue head
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_arc_next   = out_arc_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        half_next      = half_reg;
        pop            = 1'b0;
        if (out_free && head_valid) begin
            out_valid_next = 1'b1;
            if (head_ctrl.kind == ENTRY_PAIR && !half_reg) begin
                out_arc_next   = {30'd0, head_ctrl.first_arc};
                out_last_next  = 1'b0;
                out_trunc_next = 1'b0;
                half_next      = 1'b1;
            end else begin
                out_arc_next   = value_wide[31:0];
                out_last_next  = head_ctrl.last_arc;
                out_trunc_next = head_ctrl.truncated;
                half_next      = 1'b0;
                pop            = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_arc_reg   <= out_arc_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_arc_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

endmodule

FILE: rtl/oidd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the object identifier content decoder
// bound to oid_ber_content_decoder_unit, no package dependencies

module oidd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // nothing is offered on the result side straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a truncated arc always closes the identifier
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("truncated arc without last");

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result payload changed while stalled");

endmodule

bind oid_ber_content_decoder_unit oidd_checker u_oidd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: bench/oidd_arc_checker.sv
`timescale 1ns / 1ps
// arc checker for the object identifier content decoder: watches both streams,
// predicts the arcs of every accepted octet and compares them in order
// depends on oidd_pkg

module oidd_arc_checker #(
    parameter int unsigned ARC_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] content_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] arc_value
    input  logic        m_tlast,   // last_arc
    input  logic        m_tuser,   // [0] truncated
    output int          error_count,
    output int          pending_count
);

    import oidd_pkg::*;

    typedef struct packed {
        logic [31:0] arc_value;
        logic        last_arc;
        logic        truncated;
    } arc_result_t;

    // arcs predicted but not yet seen on the result stream
    arc_result_t            expected_arcs[$];
    // decoder state of the predictor
    logic                   expect_first;
    logic [ARC_WIDTH-1:0]   arc_acc;

    // append one predicted arc at the tail
    task automatic queue_arc(input arc_result_t entry);
        expected_arcs.insert(expected_arcs.size(), entry);
    endtask

    // work out the arcs that one octet yields and queue them
    task automatic predict_arcs(input logic [7:0] octet, input logic is_last);
        int unsigned lead;
        arc_result_t arc;
        if (expect_first) begin
            lead = octet / FIRST_DIVISOR;
            if (lead > 2)
                lead = 2;
            arc.arc_value = 32'(lead);
            arc.last_arc  = 1'b0;
            arc.truncated = 1'b0;
            queue_arc(arc);
            arc.arc_value = 32'(octet - lead * FIRST_DIVISOR);
            arc.last_arc  = is_last;
            queue_arc(arc);
            arc_acc      = '0;
            expect_first = is_last;
        end else begin
            arc_acc = {arc_acc[ARC_WIDTH-8:0], octet[6:0]};
            arc.arc_value = 32'(arc_acc);
            arc.last_arc  = is_last;
            arc.truncated = is_last & octet[CONT_BIT];
            if (is_last || !octet[CONT_BIT]) begin
                queue_arc(arc);
                arc_acc = '0;
            end
            if (is_last)
                expect_first = 1'b1;
        end
    endtask

    // compare result transfers, then predict from octet transfers
    always @(posedge aclk) begin
        arc_result_t want;
        arc_result_t got;
        if (!aresetn) begin
            expected_arcs.delete();
            expect_first = 1'b1;
            arc_acc      = '0;
            error_count  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.arc_value = m_tdata;
                got.last_arc  = m_tlast;
                got.truncated = m_tuser;
                if (expected_arcs.size() == 0) begin
                    $display("%0t: unexpected arc, actual arc=%0d last=%0b trunc=%0b",
                             $time, got.arc_value, got.last_arc, got.truncated);
                    error_count++;
                end else begin
                    want = expected_arcs.pop_front();
                    if (got !== want) begin
                        $display("%0t: arc mismatch, expected arc=%0d last=%0b trunc=%0b,",
                                 $time, want.arc_value, want.last_arc, want.truncated,
                                 " actual arc=%0d last=%0b trunc=%0b",
                                 got.arc_value, got.last_arc, got.truncated);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_arcs(s_tdata, s_tlast);
        end
        pending_count = expected_arcs.size();
    end

endmodule

FILE: bench/tb_oid_ber_content_decoder_unit.sv
`timescale 1ns / 1ps
// testbench top for the object identifier content decoder: drives octet
// streams with random gaps and back-pressure, and gives the verdict
// depends on oidd_pkg, oid_ber_content_decoder_unit, oidd_arc_checker

module tb_oid_ber_content_decoder_unit;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int OCTET_TARGET = 1300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] content_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] arc_value
    logic        m_tlast;   // last_arc
    logic        m_tuser;   // [0] truncated

    int          error_count;
    int          pending_count;
    int          octets_sent;
    int          cycle_count;
    // when set, neither side inserts gaps
    bit          steady;

    oid_ber_content_decoder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    oidd_arc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one octet transfer, called and returning at a falling edge
    task automatic send_octet(input logic [7:0] octet, input logic is_last);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= octet;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        octets_sent++;
        @(negedge aclk);
    endtask

    // well-formed identifier with random arcs, sometimes cut inside an arc
    task automatic send_random_identifier();
        int unsigned n_arcs;
        int unsigned n_bytes;
        bit          cut;
        bit          is_end;
        bit          is_final_arc;
        logic [6:0]  low7;
        n_arcs = $urandom_range(0, 5);
        cut    = ($urandom_range(0, 9) == 0) && (n_arcs != 0);
        send_octet(8'($urandom_range(0, 255)), n_arcs == 0);
        for (int a = 0; a < n_arcs; a++) begin
            n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6)
                                                  : $urandom_range(1, 3);
            is_final_arc = (a == n_arcs - 1);
            for (int k = 0; k < n_bytes; k++) begin
                is_end = (k == n_bytes - 1);
                low7   = 7'($urandom_range(0, 127));
                if (cut && is_final_arc && is_end)
                    send_octet({1'b1, low7}, 1'b1);
                else
                    send_octet({~is_end, low7}, is_final_arc && is_end);
            end
        end
    endtask

    // raw octets with random last flags, closed by a last octet
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            send_octet(8'($urandom_range(0, 255)),
                       (k == n - 1) || ($urandom_range(0, 3) == 0));
    endtask

    // result side back-pressure, one draw per result
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        // {last, octet}: directed identifiers covering the corner cases
        logic [8:0] directed[] = '{
            9'h100,                                 // first octet is also final
            9'h027, 9'h100,                         // first arc 0, zero arc
            9'h028, 9'h17F,                         // first arc boundary at 40
            9'h04F, 9'h086, 9'h148,                 // two-octet arc
            9'h150,                                 // first arc 2, final
            9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
            9'h0FF, 9'h17F,                         // high first octet, arc wrap
            9'h02B, 9'h080, 9'h001, 9'h181,         // leading zero, then cut
            9'h02B, 9'h1FF                          // ends on continuation
        };
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        octets_sent = 0;
        steady      = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_octet(directed[i][7:0], directed[i][8]);

        while (octets_sent < OCTET_TARGET) begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_random_identifier();
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // drain, then keep watching for anything stray
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
